/* rtl/char_lcd_cursor_writer_top_macros.svh */
// -----------------------------------------------------------------------------
// Character LCD cursor writer: assertion macros
// Implication checks that compile away for synthesis.
// -----------------------------------------------------------------------------
`ifndef CHAR_LCD_CURSOR_WRITER_TOP_MACROS_SVH
`define CHAR_LCD_CURSOR_WRITER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CLCW_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clcw assertion failed");
// Next-cycle implication.
`define CLCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clcw assertion failed");
`else
`define CLCW_ASSERT(label, clk, rst_n, ante, cons)
`define CLCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/clcw_pkg.sv */
// -----------------------------------------------------------------------------
// Character LCD cursor writer package
// Opcodes, register indexes, display constants and the job record type.
// -----------------------------------------------------------------------------
package clcw_pkg;

    // Input item opcodes.
    typedef enum logic [1:0] {
        OP_CHAR  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_HOME  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam logic CFG_LINE_LENGTH = 1'b0;
    localparam logic CFG_ROW_COUNT   = 1'b1;

    localparam logic [5:0] LINE_LENGTH_RESET = 6'd20;
    localparam logic [2:0] ROW_COUNT_RESET   = 3'd4;
    localparam logic [5:0] LINE_LENGTH_MAX   = 6'd40;
    localparam logic [2:0] MAX_ROWS          = 3'd4;

    // Controller command bytes and the newline character.
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // DDRAM start address of each display row.
    localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

    // Job queue depth and pointer width.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One byte for the controller with its register select.
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
    } t_lcd_byte;

    // One job: up to three bytes in send order.
    typedef struct packed {
        logic [1:0]      cnt;
        logic            lw;
        t_lcd_byte [2:0] bytes;
    } t_job;

endpackage

/* rtl/clcw_in_if.sv */
// -----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel that carries one cursor writer item per word.
// -----------------------------------------------------------------------------
interface clcw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] char_code;
    logic       first;

    modport source (output valid, output op, output char_code, output first, input ready);
    modport sink   (input valid, input op, input char_code, input first, output ready);
endinterface

/* rtl/clcw_out_if.sv */
// -----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel that carries one LCD nibble per word.
// -----------------------------------------------------------------------------
interface clcw_out_if;
    logic       valid;
    logic       ready;
    logic       rs;
    logic [3:0] nibble;
    logic       long_wait;
    logic       last;

    modport source (output valid, output rs, output nibble, output long_wait, output last,
                    input ready);
    modport sink   (input valid, input rs, input nibble, input long_wait, input last,
                    output ready);
endinterface

/* rtl/char_lcd_cursor_writer_top.sv */
// An item's job passes through the queue, then the serializer's job register, to the output.
// One nibble per cycle while the output is ready; a job is 2, 4 or 6 nibbles.
// A cursor reset item sends nothing; items enter the queue one per cycle while it has room.
// Reset is synchronous and active low: cursor to row 0 column 0, line length 20,
// four rows, job queue empty and no nibble pending.
// -----------------------------------------------------------------------------
// Character LCD cursor writer top level
// Front end, job queue and nibble serializer for a 4-bit character LCD bus.
// -----------------------------------------------------------------------------
module char_lcd_cursor_writer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    clcw_in_if.sink    i_in,
    clcw_out_if.source o_out
);
    import clcw_pkg::*;

    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;
    t_job push_job;
    t_job head_job;

    // Item intake and cursor tracking.
    clcw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Job queue.
    clcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // Nibble serializer.
    clcw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

/* rtl/clcw_front.sv */
// -----------------------------------------------------------------------------
// Cursor writer front end
// Accepts items, keeps the cursor and configuration, and builds byte jobs.
// -----------------------------------------------------------------------------
module clcw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [5:0]           i_cfg_data,
    clcw_in_if.sink              i_in,
    input  logic                 i_q_ready,
    output logic                 o_push,
    output clcw_pkg::t_job       o_job
);
    import clcw_pkg::*;

    logic [5:0] r_line_length;
    logic [2:0] r_row_count;
    logic [1:0] r_row, n_row;
    logic [5:0] r_col, n_col;

    logic            accept;
    t_op             op;
    logic [5:0]      cols;
    logic [2:0]      rows;
    logic [2:0]      row_inc;
    logic [1:0]      next_row;
    logic            is_nl;
    logic            wrap;
    logic [2:0]      cand_v;
    t_lcd_byte [2:0] cand;
    logic [1:0]      idx;
    t_job            job;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign op         = t_op'(i_in.op);

    // Saturate the configured geometry into its legal range.
    always_comb begin
        if (r_line_length == 6'd0) begin
            cols = 6'd1;
        end else if (r_line_length > LINE_LENGTH_MAX) begin
            cols = LINE_LENGTH_MAX;
        end else begin
            cols = r_line_length;
        end
        if (r_row_count == 3'd0) begin
            rows = 3'd1;
        end else if (r_row_count > MAX_ROWS) begin
            rows = MAX_ROWS;
        end else begin
            rows = r_row_count;
        end
    end

    // Row advance with wrap past the last row in use.
    assign row_inc  = {1'b0, r_row} + 3'd1;
    assign next_row = (row_inc >= rows) ? 2'd0 : row_inc[1:0];
    assign is_nl    = (i_in.char_code == NEWLINE_CODE);
    assign wrap     = !is_nl && (r_col >= cols);

    // Candidate bytes in send order: current address, new address, data.
    always_comb begin
        cand[0].rs   = 1'b0;
        cand[0].data = CMD_SET_ADDR | {1'b0, ROW_BASE[r_row] + {1'b0, r_col}};
        cand[1].rs   = 1'b0;
        cand[1].data = CMD_SET_ADDR | {1'b0, ROW_BASE[next_row]};
        cand[2].rs   = 1'b1;
        cand[2].data = i_in.char_code;
        cand_v       = {!is_nl, is_nl || wrap, i_in.first};
    end

    // Pack the valid candidates into the job, or build a clear or home job.
    always_comb begin
        job = '0;
        idx = 2'd0;
        case (op)
            OP_CLEAR, OP_HOME: begin
                job.cnt           = 2'd1;
                job.lw            = 1'b1;
                job.bytes[0].rs   = 1'b0;
                job.bytes[0].data = (op == OP_CLEAR) ? CMD_CLEAR : CMD_HOME;
            end
            OP_CHAR: begin
                for (int k = 0; k < 3; k++) begin
                    if (cand_v[k]) begin
                        job.bytes[idx] = cand[k];
                        idx            = idx + 2'd1;
                    end
                end
                job.cnt = idx;
            end
            default: begin
                job = '0;
            end
        endcase
    end

    assign o_push = accept && (op != OP_RESET);
    assign o_job  = job;

    // Cursor update for the accepted item.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        case (op)
            OP_CHAR: begin
                if (is_nl) begin
                    n_row = next_row;
                    n_col = 6'd0;
                end else if (wrap) begin
                    n_row = next_row;
                    n_col = 6'd1;
                end else begin
                    n_col = r_col + 6'd1;
                end
            end
            default: begin
                n_row = 2'd0;
                n_col = 6'd0;
            end
        endcase
    end

    // Cursor and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RESET;
            r_row_count   <= ROW_COUNT_RESET;
            r_row         <= 2'd0;
            r_col         <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LINE_LENGTH) begin
                    r_line_length <= i_cfg_data;
                end else begin
                    r_row_count <= i_cfg_data[2:0];
                end
            end
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

endmodule

/* rtl/clcw_queue.sv */
// -----------------------------------------------------------------------------
// Cursor writer job queue
// Small FIFO of byte jobs between the front end and the nibble serializer.
// -----------------------------------------------------------------------------
`include "char_lcd_cursor_writer_top_macros.svh"

module clcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clcw_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output clcw_pkg::t_job o_job
);
    import clcw_pkg::*;

    localparam logic [QPTR_W:0] DEPTH = (QPTR_W + 1)'(QUEUE_DEPTH);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_ready = (r_count != DEPTH);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CLCW_ASSERT(a_q_no_overflow, i_clk, i_rst_n, i_push, r_count != DEPTH)
    `CLCW_ASSERT(a_q_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `CLCW_ASSERT(a_q_count_range, i_clk, i_rst_n, 1'b1, r_count <= DEPTH)

endmodule

/* rtl/clcw_back.sv */
// -----------------------------------------------------------------------------
// Cursor writer nibble serializer
// Takes byte jobs from the queue and sends them as nibbles, high nibble first.
// -----------------------------------------------------------------------------
`include "char_lcd_cursor_writer_top_macros.svh"

module clcw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  clcw_pkg::t_job i_q_job,
    output logic           o_pop,
    clcw_out_if.source     o_out
);
    import clcw_pkg::*;

    logic       r_valid;
    t_job       r_job;
    logic [1:0] r_slot;
    logic       r_half;

    t_lcd_byte cur;
    logic      fire;
    logic      is_last;
    logic      load;

    // Select the nibble under way.
    assign cur     = r_job.bytes[r_slot];
    assign is_last = r_half && (r_slot == (r_job.cnt - 2'd1));
    assign fire    = r_valid && o_out.ready;
    assign load    = i_q_valid && (!r_valid || (fire && is_last));
    assign o_pop   = load;

    assign o_out.valid     = r_valid;
    assign o_out.rs        = cur.rs;
    assign o_out.nibble    = r_half ? cur.data[3:0] : cur.data[7:4];
    assign o_out.long_wait = r_half && r_job.lw;
    assign o_out.last      = is_last;

    // Job payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
    end

    // Serializer position within the job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 2'd0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_slot  <= 2'd0;
            r_half  <= 1'b0;
        end else if (fire) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else if (r_half) begin
                r_half <= 1'b0;
                r_slot <= r_slot + 2'd1;
            end else begin
                r_half <= 1'b1;
            end
        end
    end

    `CLCW_ASSERT(a_lw_on_cmd_end, i_clk, i_rst_n, r_valid && o_out.long_wait, !o_out.rs && is_last)
    `CLCW_ASSERT(a_slot_in_job, i_clk, i_rst_n, r_valid, (r_job.cnt != 2'd0) && (r_slot < r_job.cnt))
    `CLCW_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, fire && is_last && !i_q_valid, !r_valid)

endmodule

/* bench/testbench.sv */
// -----------------------------------------------------------------------------
// Character LCD cursor writer testbench
// Drives character, clear, home and cursor reset words into the writer and
// checks every LCD nibble against a cycle-free model of the cursor and the
// address commands. It covers directed edge cases, register extremes and
// random write sequences, with random stalls on both channels.
// -----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clcw_pkg::*;

    // Run limits and the settle time before a register write.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 380;
    localparam int CFG_SETTLE   = 8;
    localparam int DRAIN_CYCLES = 20;

    // One expected LCD nibble.
    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic       long_wait;
        logic       last;
    } t_lcd_nibble;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [5:0] i_cfg_data;

    clcw_in_if  in_if();
    clcw_out_if out_if();

    char_lcd_cursor_writer_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Model state: cursor and register copies.
    logic [1:0] cur_row;
    logic [5:0] cur_col;
    logic [5:0] line_len_reg;
    logic [2:0] row_count_reg;

    t_lcd_nibble pending_nibbles[$];
    t_lcd_nibble nibble_batch[$];

    int  items_sent;
    int  nibbles_seen;
    int  cfg_writes;
    int  nibble_mismatches;
    int  cycle_count;
    int  stall_left;
    bit  no_idle;

    string field_names[4] = '{"rs", "nibble", "long_wait", "last"};

    // Free-running clock.
    always #5 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        else if (roll < 85) return $urandom_range(1, 3);
        else if (roll < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    function automatic void add_nibble(logic rs, logic [3:0] nib, logic lw);
        t_lcd_nibble n;
        n.rs        = rs;
        n.nibble    = nib;
        n.long_wait = lw;
        n.last      = 1'b0;
        nibble_batch.push_back(n);
    endfunction

    // A byte goes out as two nibbles, high one first.
    function automatic void add_byte(logic rs, logic [7:0] b, logic lw_low);
        add_nibble(rs, b[7:4], 1'b0);
        add_nibble(rs, b[3:0], lw_low);
    endfunction

    // Set-address command for the current cursor; the sum wraps at 7 bits.
    function automatic void add_address();
        logic [6:0] addr;
        addr = ROW_BASE[cur_row] + {1'b0, cur_col};
        add_byte(1'b0, CMD_SET_ADDR | {1'b0, addr}, 1'b0);
    endfunction

    function automatic int cols_in_use();
        if (line_len_reg == 6'd0) return 1;
        if (line_len_reg > LINE_LENGTH_MAX) return int'(LINE_LENGTH_MAX);
        return int'(line_len_reg);
    endfunction

    function automatic int rows_in_use();
        if (row_count_reg == 3'd0) return 1;
        if (row_count_reg > MAX_ROWS) return int'(MAX_ROWS);
        return int'(row_count_reg);
    endfunction

    // Advance to column 0 of the next row, wrapping past the last row in use.
    function automatic void advance_row();
        int r;
        r = int'(cur_row) + 1;
        if (r >= rows_in_use()) r = 0;
        cur_row = r[1:0];
        cur_col = 6'd0;
    endfunction

    // Work out the nibbles one input word causes and queue them.
    function automatic void forecast_nibbles(t_op op, logic [7:0] ch, logic fl);
        nibble_batch.delete();
        case (op)
            OP_CLEAR, OP_HOME: begin
                add_byte(1'b0, (op == OP_CLEAR) ? CMD_CLEAR : CMD_HOME, 1'b1);
                cur_row = 2'd0;
                cur_col = 6'd0;
            end
            OP_RESET: begin
                cur_row = 2'd0;
                cur_col = 6'd0;
            end
            default: begin
                if (fl) add_address();
                if (ch == NEWLINE_CODE) begin
                    advance_row();
                    add_address();
                end else begin
                    if (int'(cur_col) >= cols_in_use()) begin
                        advance_row();
                        add_address();
                    end
                    add_byte(1'b1, ch, 1'b0);
                    cur_col = cur_col + 6'd1;
                end
            end
        endcase
        if (nibble_batch.size() > 0) nibble_batch[nibble_batch.size() - 1].last = 1'b1;
        foreach (nibble_batch[k]) pending_nibbles.push_back(nibble_batch[k]);
    endfunction

    // Send one word, after an optional gap, and wait until it is taken.
    task automatic send_item(input t_op op, input logic [7:0] ch, input logic fl);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        forecast_nibbles(op, ch, fl);
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.char_code <= ch;
        in_if.first     <= fl;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop sending and wait until every expected nibble has arrived.
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_nibbles.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [5:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LINE_LENGTH) line_len_reg = val;
        else row_count_reg = val[2:0];
        cfg_writes++;
    endtask

    // Default registers: address, data extremes, newlines, clear, home and cursor reset.
    task automatic test_basic_output();
        send_item(OP_CHAR, 8'h48, 1'b1);
        send_item(OP_CHAR, 8'h00, 1'b0);
        send_item(OP_CHAR, 8'hFF, 1'b0);
        send_item(OP_CHAR, NEWLINE_CODE, 1'b0);
        send_item(OP_CHAR, NEWLINE_CODE, 1'b1);
        send_item(OP_CLEAR, 8'hFF, 1'b1);
        send_item(OP_CHAR, 8'h5A, 1'b1);
        send_item(OP_HOME, 8'h00, 1'b0);
        send_item(OP_CHAR, 8'hA5, 1'b0);
        send_item(OP_RESET, 8'hFF, 1'b1);
        send_item(OP_CHAR, 8'h3C, 1'b1);
    endtask

    // One-character lines on two rows: every character wraps.
    task automatic test_line_wrap();
        wait_idle();
        write_register(CFG_LINE_LENGTH, 6'd1);
        write_register(CFG_ROW_COUNT, 6'd2);
        send_item(OP_CHAR, 8'h31, 1'b1);
        send_item(OP_CHAR, 8'h32, 1'b0);
        send_item(OP_CHAR, 8'h33, 1'b0);
    endtask

    // Widest line on four rows, move the cursor with newlines and text, then shrink both.
    task automatic test_shrunken_cursor();
        wait_idle();
        write_register(CFG_LINE_LENGTH, LINE_LENGTH_MAX);
        write_register(CFG_ROW_COUNT, 6'd4);
        send_item(OP_CHAR, NEWLINE_CODE, 1'b0);
        send_item(OP_CHAR, NEWLINE_CODE, 1'b0);
        send_item(OP_CHAR, NEWLINE_CODE, 1'b0);
        send_item(OP_CHAR, 8'h61, 1'b0);
        send_item(OP_CHAR, 8'h62, 1'b0);
        wait_idle();
        write_register(CFG_LINE_LENGTH, 6'd1);
        write_register(CFG_ROW_COUNT, 6'd3);
        send_item(OP_CHAR, 8'h63, 1'b0);
    endtask

    // Out-of-range register values saturate.
    task automatic test_config_saturation();
        wait_idle();
        write_register(CFG_LINE_LENGTH, 6'd0);
        write_register(CFG_ROW_COUNT, 6'd0);
        send_item(OP_CHAR, 8'h70, 1'b1);
        send_item(OP_CHAR, 8'h71, 1'b0);
        send_item(OP_CHAR, NEWLINE_CODE, 1'b0);
        wait_idle();
        write_register(CFG_LINE_LENGTH, 6'd63);
        write_register(CFG_ROW_COUNT, 6'd7);
        send_item(OP_CHAR, NEWLINE_CODE, 1'b1);
        send_item(OP_CHAR, 8'h80, 1'b0);
    endtask

    // One write: an addressed first character, then text and newlines.
    task automatic send_write_sequence();
        int len;
        len = $urandom_range(1, 24);
        send_item(OP_CHAR, 8'($urandom_range(0, 255)), 1'b1);
        for (int k = 1; k < len; k++) begin
            if ($urandom_range(0, 99) < 12) send_item(OP_CHAR, NEWLINE_CODE, 1'b0);
            else send_item(OP_CHAR, 8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    function automatic logic [5:0] pick_line_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 6'($urandom_range(1, 6));
        else if (roll < 60) return 6'($urandom_range(7, 40));
        else if (roll < 70) return LINE_LENGTH_MAX;
        else if (roll < 80) return 6'd1;
        else if (roll < 90) return 6'd0;
        else return 6'($urandom_range(41, 63));
    endfunction

    // Random phases, each with fresh registers; every fourth runs without gaps.
    task automatic test_random_traffic();
        int goal;
        int phase;
        int phase_end;
        int roll;
        goal  = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < goal) begin
            wait_idle();
            write_register(CFG_LINE_LENGTH, pick_line_length());
            write_register(CFG_ROW_COUNT, 6'($urandom_range(0, 63)));
            no_idle   = (phase % 4 == 3);
            phase_end = items_sent + $urandom_range(30, 70);
            while (items_sent < phase_end && items_sent < goal) begin
                roll = $urandom_range(0, 99);
                if (roll < 78) begin
                    send_write_sequence();
                end else if (roll < 84) begin
                    send_item(($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_HOME,
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else if (roll < 89) begin
                    send_item(OP_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else if (roll < 97) begin
                    send_item(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end else begin
                    // Let the output side drain completely in mid-phase.
                    wait_idle();
                end
            end
            no_idle = 1'b0;
            phase++;
        end
    endtask

    // Output side: random stalls, none while a gap-free phase runs.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (no_idle || stall_left == 0) begin
            out_if.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end else begin
            out_if.ready <= 1'b0;
            stall_left--;
        end
    end

    // Compare each accepted word with the oldest expected nibble.
    always @(posedge i_clk) begin : check_nibble
        t_lcd_nibble want;
        logic [3:0]  want_f [4];
        logic [3:0]  got_f [4];
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            nibbles_seen++;
            if (pending_nibbles.size() == 0) begin
                nibble_mismatches++;
                $display("%0t: unexpected word rs=%b nibble=%h long_wait=%b last=%b",
                         $time, out_if.rs, out_if.nibble, out_if.long_wait, out_if.last);
            end else begin
                want   = pending_nibbles.pop_front();
                want_f = '{{3'b000, want.rs}, want.nibble,
                           {3'b000, want.long_wait}, {3'b000, want.last}};
                got_f  = '{{3'b000, out_if.rs}, out_if.nibble,
                           {3'b000, out_if.long_wait}, {3'b000, out_if.last}};
                for (int k = 0; k < 4; k++) begin
                    if (got_f[k] !== want_f[k]) begin
                        nibble_mismatches++;
                        $display("%0t: %s expected %h got %h",
                                 $time, field_names[k], want_f[k], got_f[k]);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LINE_LENGTH;
        i_cfg_data      = 6'd0;
        in_if.valid     = 1'b0;
        in_if.op        = OP_CHAR;
        in_if.char_code = 8'd0;
        in_if.first     = 1'b0;
        out_if.ready    = 1'b0;
        no_idle         = 1'b0;
        stall_left      = 0;
        cur_row         = 2'd0;
        cur_col         = 6'd0;
        line_len_reg    = LINE_LENGTH_RESET;
        row_count_reg   = ROW_COUNT_RESET;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_output();
        test_line_wrap();
        test_shrunken_cursor();
        test_config_saturation();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words and checked %0d nibbles over %0d register writes,",
                 items_sent, nibbles_seen, cfg_writes);
        $display("covering wraps, newlines, clear/home and saturated line and row settings.");
        if (nibble_mismatches == 0 && pending_nibbles.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
